/* sv/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and constants of the rule language tokenizer
// Token kinds, operator codes, lexer modes and the front-to-back command word.
// ----------------------------------------------------------------------------
package rlt_pkg;

   localparam int POS_BITS = 16;
   localparam int NUM_BITS = 64;
   localparam int HOLD_DEPTH = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_ADDR_BITS = 2;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   localparam logic [2:0] KIND_OP    = 3'd0;
   localparam logic [2:0] KIND_WCHAR = 3'd1;
   localparam logic [2:0] KIND_WEND  = 3'd2;
   localparam logic [2:0] KIND_SCHAR = 3'd3;
   localparam logic [2:0] KIND_SEND  = 3'd4;
   localparam logic [2:0] KIND_NUM   = 3'd5;
   localparam logic [2:0] KIND_END   = 3'd6;
   localparam logic [2:0] KIND_ERR   = 3'd7;

   localparam logic [4:0] OP_PIPE    = 5'd16;
   localparam logic [4:0] OP_OROR    = 5'd17;
   localparam logic [4:0] OP_BANG    = 5'd18;
   localparam logic [4:0] OP_NE      = 5'd19;
   localparam logic [4:0] OP_DOLPAR  = 5'd20;
   localparam logic [4:0] OP_ARROW   = 5'd21;
   localparam logic [4:0] OP_FEATURE = 5'd22;
   localparam logic [4:0] OP_CLASS   = 5'd23;

   localparam logic [3:0] MODE_IDLE    = 4'd0;
   localparam logic [3:0] MODE_COMMENT = 4'd1;
   localparam logic [3:0] MODE_WORD    = 4'd2;
   localparam logic [3:0] MODE_NUMBER  = 4'd3;
   localparam logic [3:0] MODE_STRING  = 4'd4;
   localparam logic [3:0] MODE_ESCAPE  = 4'd5;
   localparam logic [3:0] MODE_PIPE    = 4'd6;
   localparam logic [3:0] MODE_BANG    = 4'd7;
   localparam logic [3:0] MODE_DOLLAR  = 4'd8;
   localparam logic [3:0] MODE_MINUS   = 4'd9;

   typedef struct packed {
      logic [2:0]          kind;
      logic [4:0]          operator_code;
      logic [7:0]          char_value;
      logic [NUM_BITS-1:0] number_value;
      logic [POS_BITS-1:0] token_line;
      logic [POS_BITS-1:0] token_column;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } char_type;

   // Work for the back end: up to two plain tokens and a held-character flush.
   typedef struct packed {
      logic                flush_held;  // emit held chars before tok_a
      logic [2:0]          hold_count;
      logic [HOLD_DEPTH*8-1:0] hold_chars;
      logic                a_valid;
      token_type           tok_a;
      logic                b_valid;
      token_type           tok_b;
   } cmd_type;

   function automatic logic [4:0] single_op(input logic [7:0] c);
      case (c)
         8'h28: single_op = 5'd0;   8'h29: single_op = 5'd1;
         8'h5B: single_op = 5'd2;   8'h5D: single_op = 5'd3;
         8'h7B: single_op = 5'd4;   8'h7D: single_op = 5'd5;
         8'h2C: single_op = 5'd6;   8'h3D: single_op = 5'd7;
         8'h3A: single_op = 5'd8;   8'h3B: single_op = 5'd9;
         8'h5F: single_op = 5'd10;  8'h7E: single_op = 5'd11;
         8'h2F: single_op = 5'd12;  8'h2A: single_op = 5'd13;
         8'h2B: single_op = 5'd14;  8'h3F: single_op = 5'd15;
         default: single_op = 5'd31;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
      logic [55:0] s;
      begin
         case (k)
            2'd0: s = "feature";
            2'd1: s = {"class", 16'h0};
            default: s = {"NOT", 32'h0};
         endcase
         kw_char = s[55 - 8*i -: 8];
      end
   endfunction

endpackage

/* sv/rlt_if.sv */
// ----------------------------------------------------------------------------
// rlt_char_if / rlt_token_if: valid-ready channels of the tokenizer
// One interface per payload type, each with source and sink modports.
// ----------------------------------------------------------------------------
interface rlt_char_if import rlt_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rlt_token_if import rlt_pkg::*; ();
   logic      valid;
   logic      ready;
   token_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/rule_language_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// rule_language_tokenizer_unit: streaming lexer for the rule language
// Front end lexes bytes into commands; back end emits tokens.
// ----------------------------------------------------------------------------
// The command is registered in the queue, each token in the output register.
// Throughput: one byte per cycle while the queue has room; a byte with n
// tokens is emitted token by token, absorbed by the 4-entry command queue.
// Reset: synchronous; lexer returns to idle, position counters to zero.
module rule_language_tokenizer_unit import rlt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rlt_char_if.sink    req,
   rlt_token_if.source rsp
);

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;

   rlt_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_data(req.data), .in_ready(req.ready),
      .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
   );

   rlt_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
      .rd_valid(q_valid), .rd_data(q_cmd), .rd_ready(q_ready)
   );

   rlt_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(q_ready),
      .rsp(rsp)
   );

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.kind == KIND_END |-> rsp.data.last)
      else $error("end token not last");

   a_queue_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == f_ready)
      else $error("front stalled with queue space");

endmodule

/* sv/rlt_front.sv */
// ----------------------------------------------------------------------------
// rlt_front: lexer state machine
// Accepts one byte per cycle while the queue is ready, updates position and mode, builds a command.
// ----------------------------------------------------------------------------
module rlt_front import rlt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  char_type in_data,
   output logic     in_ready,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);

   logic [3:0]            mode_ff, mode_in;
   logic [HOLD_DEPTH*8-1:0] held_ff, held_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [2:0]            flags_ff, flags_in;
   logic [NUM_BITS-1:0]   acc_ff, acc_in;
   logic [POS_BITS-1:0]   line_ff, line_in, col_ff, col_in;
   logic [POS_BITS-1:0]   sline_ff, sline_in, scol_ff, scol_in;
   logic [NUM_BITS-1:0]   acc_x10;

   assign in_ready = cmd_ready;
   assign cmd_valid = in_valid;
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1);

   function automatic token_type mk(input logic [2:0] k, input logic [4:0] op,
      input logic [7:0] ch, input logic [NUM_BITS-1:0] n,
      input logic [POS_BITS-1:0] ln, input logic [POS_BITS-1:0] cl);
      token_type t;
      begin
         t.kind = k; t.operator_code = op; t.char_value = ch;
         t.number_value = n; t.token_line = ln; t.token_column = cl; t.last = 1'b0;
         mk = t;
      end
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       wordb, digit, blank, close_word, fresh;
      logic [2:0] m;
      logic [4:0] op;
      logic [POS_BITS-1:0] sl, sc;
      c = in_data.char_byte;
      m = 3'd0;
      op = 5'd0;
      mode_in = mode_ff; held_in = held_ff; cnt_in = cnt_ff; flags_in = flags_ff;
      acc_in = acc_ff; line_in = line_ff; col_in = col_ff;
      sline_in = sline_ff; scol_in = scol_ff;
      cmd = '0;
      cmd.hold_chars = held_ff;
      cmd.hold_count = cnt_ff;
      wordb = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c[7];
      digit = c >= 8'h30 && c <= 8'h39;
      blank = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      close_word = 1'b0;
      fresh = 1'b0;
      sl = sline_ff; sc = scol_ff;
      if (in_data.end_of_input) begin
         case (mode_ff)
            MODE_WORD: close_word = 1'b1;
            MODE_NUMBER: begin
               cmd.a_valid = 1'b1;
               cmd.tok_a = mk(KIND_NUM, 5'd0, 8'd0, acc_ff, sl, sc);
            end
            MODE_PIPE: begin
               cmd.a_valid = 1'b1; cmd.tok_a = mk(KIND_OP, OP_PIPE, 8'd0, '0, sl, sc);
            end
            MODE_BANG: begin
               cmd.a_valid = 1'b1; cmd.tok_a = mk(KIND_OP, OP_BANG, 8'd0, '0, sl, sc);
            end
            MODE_DOLLAR, MODE_MINUS, MODE_STRING, MODE_ESCAPE: begin
               cmd.a_valid = 1'b1; cmd.tok_a = mk(KIND_ERR, 5'd0, 8'd0, '0, sl, sc);
            end
            default: ;
         endcase
         if (close_word) begin
            cmd.a_valid = 1'b1;
            if (flags_ff[0] && cnt_ff == 3'd7)
               cmd.tok_a = mk(KIND_OP, OP_FEATURE, 8'd0, '0, sl, sc);
            else if (flags_ff[1] && cnt_ff == 3'd5)
               cmd.tok_a = mk(KIND_OP, OP_CLASS, 8'd0, '0, sl, sc);
            else if (flags_ff[2] && cnt_ff == 3'd3)
               cmd.tok_a = mk(KIND_OP, OP_BANG, 8'd0, '0, sl, sc);
            else begin
               cmd.flush_held = 1'b1;
               cmd.tok_a = mk(KIND_WEND, 5'd0, 8'd0, '0, sl, sc);
            end
         end
         cmd.b_valid = 1'b1;
         cmd.tok_b = mk(KIND_END, 5'd0, 8'd0, '0, line_ff, col_ff);
         mode_in = MODE_IDLE; cnt_in = 3'd0; flags_in = 3'd7;
      end else begin
         if (c == 8'h0A) begin
            if (line_ff != POS_MAX) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff != POS_MAX) col_in = col_ff + 1'b1;
         case (mode_ff)
            MODE_COMMENT: if (c == 8'h0A) mode_in = MODE_IDLE;
            MODE_WORD: begin
               if (wordb) begin
                  if (flags_ff == 3'd0) begin
                     cmd.b_valid = 1'b1;
                     cmd.tok_b = mk(KIND_WCHAR, 5'd0, c, '0, sl, sc);
                  end else begin
                     m = 3'd0;
                     for (int k = 0; k < 3; k++)
                        if (kw_char(2'(k), cnt_ff) == c && kw_char(2'(k), cnt_ff) != 8'd0)
                           m[k] = 1'b1;
                     if ((flags_ff & m) != 3'd0 && cnt_ff != 3'd7) begin
                        flags_in = flags_ff & m;
                        held_in[55 - 8*cnt_ff -: 8] = c;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        flags_in = 3'd0;
                        cmd.flush_held = 1'b1;
                        cnt_in = 3'd0;
                        cmd.b_valid = 1'b1;
                        cmd.tok_b = mk(KIND_WCHAR, 5'd0, c, '0, sl, sc);
                     end
                  end
               end else begin
                  close_word = 1'b1;
                  fresh = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (digit) acc_in = acc_x10 + NUM_BITS'(c - 8'h30);
               else begin
                  cmd.a_valid = 1'b1;
                  cmd.tok_a = mk(KIND_NUM, 5'd0, 8'd0, acc_ff, sl, sc);
                  fresh = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == 8'h22) begin
                  cmd.b_valid = 1'b1; cmd.tok_b = mk(KIND_SEND, 5'd0, 8'd0, '0, sl, sc);
                  mode_in = MODE_IDLE;
               end else if (c == 8'h5C) mode_in = MODE_ESCAPE;
               else begin
                  cmd.b_valid = 1'b1; cmd.tok_b = mk(KIND_SCHAR, 5'd0, c, '0, sl, sc);
               end
            end
            MODE_ESCAPE: begin
               if (c == 8'h22 || c == 8'h5C) begin
                  cmd.b_valid = 1'b1; cmd.tok_b = mk(KIND_SCHAR, 5'd0, c, '0, sl, sc);
               end else if (c == 8'h6E) begin
                  cmd.b_valid = 1'b1; cmd.tok_b = mk(KIND_SCHAR, 5'd0, 8'h0A, '0, sl, sc);
               end
               mode_in = MODE_STRING;
            end
            MODE_PIPE: begin
               cmd.a_valid = 1'b1;
               if (c == 8'h7C) begin
                  cmd.tok_a = mk(KIND_OP, OP_OROR, 8'd0, '0, sl, sc); mode_in = MODE_IDLE;
               end else begin
                  cmd.tok_a = mk(KIND_OP, OP_PIPE, 8'd0, '0, sl, sc); fresh = 1'b1;
               end
            end
            MODE_BANG: begin
               cmd.a_valid = 1'b1;
               if (c == 8'h3D) begin
                  cmd.tok_a = mk(KIND_OP, OP_NE, 8'd0, '0, sl, sc); mode_in = MODE_IDLE;
               end else begin
                  cmd.tok_a = mk(KIND_OP, OP_BANG, 8'd0, '0, sl, sc); fresh = 1'b1;
               end
            end
            MODE_DOLLAR, MODE_MINUS: begin
               cmd.a_valid = 1'b1;
               if (mode_ff == MODE_DOLLAR && c == 8'h28) begin
                  cmd.tok_a = mk(KIND_OP, OP_DOLPAR, 8'd0, '0, sl, sc); mode_in = MODE_IDLE;
               end else if (mode_ff == MODE_MINUS && c == 8'h3E) begin
                  cmd.tok_a = mk(KIND_OP, OP_ARROW, 8'd0, '0, sl, sc); mode_in = MODE_IDLE;
               end else begin
                  cmd.tok_a = mk(KIND_ERR, 5'd0, 8'd0, '0, sl, sc); fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase
         if (close_word) begin
            cmd.a_valid = 1'b1;
            if (flags_ff[0] && cnt_ff == 3'd7)
               cmd.tok_a = mk(KIND_OP, OP_FEATURE, 8'd0, '0, sl, sc);
            else if (flags_ff[1] && cnt_ff == 3'd5)
               cmd.tok_a = mk(KIND_OP, OP_CLASS, 8'd0, '0, sl, sc);
            else if (flags_ff[2] && cnt_ff == 3'd3)
               cmd.tok_a = mk(KIND_OP, OP_BANG, 8'd0, '0, sl, sc);
            else begin
               cmd.flush_held = 1'b1;
               cmd.tok_a = mk(KIND_WEND, 5'd0, 8'd0, '0, sl, sc);
            end
            cnt_in = 3'd0; flags_in = 3'd7;
         end
         // a new token starts at the position after this byte moved it
         if (fresh) begin
            op = single_op(c);
            mode_in = MODE_IDLE;
            sline_in = line_in; scol_in = col_in;
            if (blank) ;
            else if (op != 5'd31) begin
               cmd.b_valid = 1'b1;
               cmd.tok_b = mk(KIND_OP, op, 8'd0, '0, line_in, col_in);
            end else if (c == 8'h23) mode_in = MODE_COMMENT;
            else if (c == 8'h7C) mode_in = MODE_PIPE;
            else if (c == 8'h21) mode_in = MODE_BANG;
            else if (c == 8'h24) mode_in = MODE_DOLLAR;
            else if (c == 8'h2D) mode_in = MODE_MINUS;
            else if (c == 8'h22) mode_in = MODE_STRING;
            else if (wordb) begin
               mode_in = MODE_WORD;
               m = 3'd0;
               for (int k = 0; k < 3; k++)
                  if (kw_char(2'(k), 3'd0) == c) m[k] = 1'b1;
               if (m != 3'd0) begin
                  flags_in = m; held_in[55 -: 8] = c; cnt_in = 3'd1;
               end else begin
                  flags_in = 3'd0; cnt_in = 3'd0;
                  cmd.b_valid = 1'b1;
                  cmd.tok_b = mk(KIND_WCHAR, 5'd0, c, '0, line_in, col_in);
               end
            end else if (digit) begin
               acc_in = NUM_BITS'(c - 8'h30); mode_in = MODE_NUMBER;
            end else begin
               cmd.b_valid = 1'b1;
               cmd.tok_b = mk(KIND_ERR, 5'd0, 8'd0, '0, line_in, col_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; cnt_ff <= 3'd0; flags_ff <= 3'd7; acc_ff <= '0;
         line_ff <= '0; col_ff <= '0; sline_ff <= '0; scol_ff <= '0;
      end else if (in_valid && in_ready) begin
         mode_ff <= mode_in; cnt_ff <= cnt_in; flags_ff <= flags_in; acc_ff <= acc_in;
         line_ff <= line_in; col_ff <= col_in; sline_ff <= sline_in; scol_ff <= scol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) held_ff <= held_in;
   end

endmodule

/* sv/rlt_queue.sv */
// ----------------------------------------------------------------------------
// rlt_queue: command queue between front and back end
// Small register FIFO; ready while a slot is free.
// ----------------------------------------------------------------------------
module rlt_queue import rlt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  cmd_type wr_data,
   output logic    wr_ready,
   output logic    rd_valid,
   output cmd_type rd_data,
   input  logic    rd_ready
);

   cmd_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0] wp_ff, rp_ff;
   logic [QUEUE_ADDR_BITS:0]   cnt_ff;
   logic push, pop;

   assign wr_ready = cnt_ff != (QUEUE_ADDR_BITS+1)'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_ADDR_BITS+1)'(push) - (QUEUE_ADDR_BITS+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

endmodule

/* sv/rlt_back.sv */
// ----------------------------------------------------------------------------
// rlt_back: token sequencer
// Walks one command: held characters, then token A, then token B.
// ----------------------------------------------------------------------------
module rlt_back import rlt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_ready,
   rlt_token_if.source   rsp
);

   localparam logic [1:0] PH_HOLD = 2'd0;
   localparam logic [1:0] PH_A = 2'd1;
   localparam logic [1:0] PH_B = 2'd2;

   logic [1:0] ph_ff, ph_in;
   logic [2:0] idx_ff, idx_in;
   logic       emit, is_last, adv_ok, skid_ready;
   token_type  tok;
   token_type  out_ff;
   logic       out_v_ff;
   logic       has_hold, has_a, has_b;

   assign has_hold = cmd.flush_held && cmd.hold_count != 3'd0;
   assign has_a = cmd.a_valid;
   assign has_b = cmd.b_valid;
   assign skid_ready = !out_v_ff || rsp.ready;

   always_comb begin
      ph_in = ph_ff; idx_in = idx_ff;
      tok = cmd.tok_a;
      emit = 1'b0; is_last = 1'b0; adv_ok = 1'b0;
      case (ph_ff)
         PH_HOLD: begin
            if (has_hold) begin
               emit = 1'b1;
               tok = cmd.tok_a;
               tok.kind = KIND_WCHAR; tok.operator_code = 5'd0;
               tok.char_value = cmd.hold_chars[55 - 8*idx_ff -: 8];
               if (!cmd.a_valid && !cmd.b_valid) ;
               if (idx_ff + 1'b1 == cmd.hold_count) begin
                  is_last = !has_a && !has_b;
                  tok.token_line = has_a ? cmd.tok_a.token_line : cmd.tok_b.token_line;
                  tok.token_column = has_a ? cmd.tok_a.token_column : cmd.tok_b.token_column;
               end
            end else if (has_a) begin
               emit = 1'b1; tok = cmd.tok_a; is_last = !has_b;
            end else if (has_b) begin
               emit = 1'b1; tok = cmd.tok_b; is_last = 1'b1;
            end else is_last = 1'b1;
            if (has_hold && !has_a && idx_ff == 3'd0) begin
               tok.token_line = cmd.tok_b.token_line;
               tok.token_column = cmd.tok_b.token_column;
            end
            if (has_hold && has_a) begin
               tok.token_line = cmd.tok_a.token_line;
               tok.token_column = cmd.tok_a.token_column;
            end else if (has_hold) begin
               tok.token_line = cmd.tok_b.token_line;
               tok.token_column = cmd.tok_b.token_column;
            end
         end
         PH_A: begin
            emit = 1'b1; tok = cmd.tok_a; is_last = !has_b;
         end
         PH_B: begin
            emit = 1'b1; tok = cmd.tok_b; is_last = 1'b1;
         end
         default: is_last = 1'b1;
      endcase
      tok.last = is_last;
      adv_ok = cmd_valid && (skid_ready || !emit);
      if (adv_ok && !is_last) begin
         if (ph_ff == PH_HOLD && has_hold && idx_ff + 1'b1 != cmd.hold_count)
            idx_in = idx_ff + 1'b1;
         else if (ph_ff == PH_HOLD && has_hold && has_a) begin
            ph_in = PH_A; idx_in = 3'd0;
         end else begin
            ph_in = PH_B; idx_in = 3'd0;
         end
      end else if (adv_ok) begin
         ph_in = PH_HOLD; idx_in = 3'd0;
      end
   end

   assign cmd_ready = adv_ok && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_HOLD; idx_ff <= 3'd0; out_v_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; idx_ff <= idx_in;
         if (skid_ready) out_v_ff <= cmd_valid && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_ready) out_ff <= tok;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;

endmodule
